### hw/rtl/wahenc_pkg.sv
// Shared types and code-word constants for the WAH bitmap encoder.
// No dependencies; imported by every wahenc module.
`timescale 1ns / 1ps

package wahenc_pkg;

   localparam int MAX_WORDS = 4;
   localparam int CODE_W    = 32;
   localparam int TOTAL_W   = 33;
   localparam int COUNT_W   = 30;

   localparam logic [CODE_W-1:0] W_FILL      = 32'h8000_0000;
   localparam logic [CODE_W-1:0] W_ONEFILL   = 32'hC000_0000;
   localparam logic [CODE_W-1:0] W_COUNTMASK = 32'h3FFF_FFFF;
   localparam logic [CODE_W-1:0] W_ONEFULL   = W_ONEFILL | W_COUNTMASK;

   // Words produced by one input item, in output order.
   typedef struct packed {
      logic                              valid;
      logic [2:0]                        count;
      logic                              last;
      logic [MAX_WORDS-1:0][CODE_W-1:0] words;
      logic [TOTAL_W-1:0]                total;
   } bundle_type;

   function automatic logic [CODE_W-1:0] zero_fill(input logic [COUNT_W-1:0] count);
      return W_FILL | {2'b00, count};
   endfunction

endpackage

### hw/rtl/wahenc_divider.sv
// Input register and constant divide of the position by the literal width.
// Reciprocal multiply, then one compare-and-subtract correction. Uses wahenc_pkg.
`timescale 1ns / 1ps

module wahenc_divider
   import wahenc_pkg::*;
#(
   parameter int LITERAL_BITS = 31,
   localparam int QW = $clog2((64'd1 << 32) / LITERAL_BITS + 1),
   localparam int RW = $clog2(LITERAL_BITS)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic [31:0]                       in_pos,
   input  logic                              in_fin,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic [QW-1:0]                     out_q,
   output logic [RW-1:0]                     out_r,
   output logic [TOTAL_W-1:0]                out_wep,
   output logic                              out_fin
);

   localparam int SHIFT = 32 + $clog2(LITERAL_BITS) - 1;
   localparam logic [63:0] RECIP = (64'd1 << SHIFT) / LITERAL_BITS;
   localparam logic [31:0] RECIP_LO = RECIP[31:0];

   logic                 v1_ff, v2_ff, v3_ff;
   logic [31:0]          p1_ff, p2_ff;
   logic                 f1_ff, f2_ff, f3_ff;
   logic [QW-1:0]        q0_ff, q0_in;
   logic [QW-1:0]        q_ff, q_in;
   logic [RW-1:0]        r_ff, r_in;
   logic [TOTAL_W-1:0]   wep_ff, wep_in;
   logic [63:0]          prod;
   logic [TOTAL_W-1:0]   rem_wide;
   logic [RW:0]          rem;
   logic                 adv1, adv2, adv3;

   assign adv3     = !v3_ff || out_ready;
   assign adv2     = !v2_ff || adv3;
   assign adv1     = !v1_ff || adv2;
   assign in_ready = adv1;

   always_comb begin
      prod  = 64'(p1_ff) * 64'(RECIP_LO);
      q0_in = QW'(prod >> SHIFT);
   end

   always_comb begin
      rem_wide = 33'(p2_ff) - 33'(q0_ff) * 33'(LITERAL_BITS);
      rem      = rem_wide[RW:0];
      if (rem >= (RW+1)'(LITERAL_BITS)) begin
         q_in = q0_ff + QW'(1);
         r_in = RW'(rem - (RW+1)'(LITERAL_BITS));
      end else begin
         q_in = q0_ff;
         r_in = rem[RW-1:0];
      end
      wep_in = 33'(p2_ff) - 33'(r_in) + 33'(LITERAL_BITS - 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= in_valid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         p1_ff <= in_pos;
         f1_ff <= in_fin;
      end
      if (adv2) begin
         p2_ff <= p1_ff;
         f2_ff <= f1_ff;
         q0_ff <= q0_in;
      end
      if (adv3) begin
         q_ff   <= q_in;
         r_ff   <= r_in;
         wep_ff <= wep_in;
         f3_ff  <= f2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign out_q     = q_ff;
   assign out_r     = r_ff;
   assign out_wep   = wep_ff;
   assign out_fin   = f3_ff;

endmodule

### hw/rtl/wahenc_encoder.sv
// Bitmap state: literal under construction, held word and word index.
// Turns one divided position into a bundle of up to four code words. Uses wahenc_pkg.
`timescale 1ns / 1ps

module wahenc_encoder
   import wahenc_pkg::*;
#(
   parameter int LITERAL_BITS = 31,
   localparam int QW = $clog2((64'd1 << 32) / LITERAL_BITS + 1),
   localparam int RW = $clog2(LITERAL_BITS)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [QW-1:0]       in_q,
   input  logic [RW-1:0]       in_r,
   input  logic [TOTAL_W-1:0]  in_wep,
   input  logic                in_fin,
   input  logic                sink_free,
   output bundle_type          bundle
);

   localparam int LW = LITERAL_BITS;

   typedef struct packed {
      logic              emit;
      logic [CODE_W-1:0] word;
      logic [CODE_W-1:0] held;
   } step_type;

   function automatic step_type push_word(input logic [CODE_W-1:0] h, input logic hv,
                                          input logic [CODE_W-1:0] w);
      step_type s;
      s.emit = hv;
      s.word = h;
      s.held = w;
      return s;
   endfunction

   function automatic step_type close_lit(input logic [CODE_W-1:0] h, input logic hv,
                                          input logic [LW-1:0] a);
      step_type s;
      if (a == {LW{1'b1}}) begin
         if (hv && h[31:30] == 2'b11 && h != W_ONEFULL) begin
            s.emit = 1'b0;
            s.word = h;
            s.held = h + 32'd1;
         end else begin
            s = push_word(h, hv, W_ONEFILL | 32'd1);
         end
      end else begin
         s = push_word(h, hv, 32'(a));
      end
      return s;
   endfunction

   logic [LW-1:0]         acc_ff, acc_in;
   logic [QW-1:0]         k_ff, k_in;
   logic [TOTAL_W-1:0]    wep_ff, wep_in;
   logic [CODE_W-1:0]     held_ff, held_in;
   logic                  held_valid_ff, held_valid_in;
   logic                  started_ff, started_in;

   logic [MAX_WORDS-1:0][CODE_W-1:0] words;
   logic [2:0]            n;
   logic [QW-1:0]         gap;
   logic [RW-1:0]         idx;
   logic [TOTAL_W-1:0]    total;
   step_type              s;
   logic                  fire;

   always_comb begin
      acc_in        = acc_ff;
      k_in          = k_ff;
      wep_in        = wep_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      started_in    = started_ff;
      words         = '0;
      n             = '0;
      total         = '0;
      gap           = '0;
      s             = '0;
      idx           = RW'(LITERAL_BITS - 1) - in_r;

      if (!started_in) begin
         k_in   = in_q;
         wep_in = in_wep;
         acc_in = '0;
         if (in_q != '0) begin
            s = push_word(held_in, held_valid_in, zero_fill(COUNT_W'(in_q)));
            if (s.emit) begin
               words[n[1:0]] = s.word;
               n = n + 3'd1;
            end
            held_in       = s.held;
            held_valid_in = 1'b1;
         end
         started_in = 1'b1;
      end

      if (in_q > k_in) begin
         s = close_lit(held_in, held_valid_in, acc_in);
         if (s.emit) begin
            words[n[1:0]] = s.word;
            n = n + 3'd1;
         end
         held_in       = s.held;
         held_valid_in = 1'b1;
         gap = in_q - k_in - QW'(1);
         if (gap != '0) begin
            s = push_word(held_in, held_valid_in, zero_fill(COUNT_W'(gap)));
            if (s.emit) begin
               words[n[1:0]] = s.word;
               n = n + 3'd1;
            end
            held_in = s.held;
         end
         k_in   = in_q;
         wep_in = in_wep;
         acc_in = LW'(1) << idx;
      end else if (in_q == k_in) begin
         acc_in = acc_in | (LW'(1) << idx);
      end

      if (in_fin) begin
         s = close_lit(held_in, held_valid_in, acc_in);
         if (s.emit) begin
            words[n[1:0]] = s.word;
            n = n + 3'd1;
         end
         words[n[1:0]] = s.held;
         n = n + 3'd1;
         total = wep_in + 33'd1;
         acc_in        = '0;
         k_in          = '0;
         wep_in        = 33'(LITERAL_BITS - 1);
         held_in       = '0;
         held_valid_in = 1'b0;
         started_in    = 1'b0;
      end
   end

   assign in_ready = sink_free || (n == 3'd0);
   assign fire     = in_valid && in_ready;

   always_comb begin
      bundle.valid = fire && (n != 3'd0);
      bundle.count = n;
      bundle.last  = in_fin;
      bundle.words = words;
      bundle.total = total;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff        <= '0;
         k_ff          <= '0;
         wep_ff        <= 33'(LITERAL_BITS - 1);
         held_ff       <= '0;
         held_valid_ff <= 1'b0;
         started_ff    <= 1'b0;
      end else if (fire) begin
         acc_ff        <= acc_in;
         k_ff          <= k_in;
         wep_ff        <= wep_in;
         held_ff       <= held_in;
         held_valid_ff <= held_valid_in;
         started_ff    <= started_in;
      end
   end

endmodule

### hw/rtl/wahenc_serializer.sv
// Result register: holds one bundle and hands its words out one transfer at a time.
// Uses wahenc_pkg.
`timescale 1ns / 1ps

module wahenc_serializer
   import wahenc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  bundle_type          bundle,
   output logic                free,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [CODE_W-1:0]   out_word,
   output logic                out_last,
   output logic [TOTAL_W-1:0]  out_total
);

   logic                              bv_ff;
   logic [1:0]                        idx_ff;
   logic [2:0]                        cnt_ff;
   logic                              last_ff;
   logic [MAX_WORDS-1:0][CODE_W-1:0] words_ff;
   logic [TOTAL_W-1:0]                total_ff;
   logic                              taken, at_end;

   assign at_end    = (3'(idx_ff) + 3'd1) == cnt_ff;
   assign taken     = bv_ff && out_ready;
   assign free      = !bv_ff || (taken && at_end);
   assign out_valid = bv_ff;
   assign out_word  = words_ff[idx_ff];
   assign out_last  = last_ff && at_end;
   assign out_total = out_last ? total_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         bv_ff  <= 1'b0;
         idx_ff <= '0;
      end else if (bundle.valid) begin
         bv_ff  <= 1'b1;
         idx_ff <= '0;
      end else if (taken) begin
         if (at_end) bv_ff <= 1'b0;
         else        idx_ff <= idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (bundle.valid) begin
         cnt_ff   <= bundle.count;
         last_ff  <= bundle.last;
         words_ff <= bundle.words;
         total_ff <= bundle.total;
      end
   end

endmodule

### hw/rtl/wah_encode_sorted_positions_core.sv
// WAH bitmap encoder for a sorted stream of set-bit positions.
// Path: divider input, estimate and result registers, encoder, result register.
// Throughput: one position per cycle while no bundle waits on the result register;
// an item's n words (n up to 4) hold it until all leave by the one-word-wide output.
// Reset: synchronous, active high; clears the pipeline and starts a new bitmap.
`timescale 1ns / 1ps

module wah_encode_sorted_positions_core
   import wahenc_pkg::*;
#(
   parameter int LITERAL_BITS = 31
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] position
   input  logic        req_tlast,   // final_item
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [31:0] code_word, [64:32] total_bits, [71:65] zero
   output logic        rsp_tlast    // final_word
);

   localparam int QW = $clog2((64'd1 << 32) / LITERAL_BITS + 1);
   localparam int RW = $clog2(LITERAL_BITS);

   logic                d_valid, d_ready, d_fin;
   logic [QW-1:0]       d_q;
   logic [RW-1:0]       d_r;
   logic [TOTAL_W-1:0]  d_wep;
   bundle_type          bundle;
   logic                sink_free;
   logic [CODE_W-1:0]   code_word;
   logic [TOTAL_W-1:0]  total_bits;

   wahenc_divider #(.LITERAL_BITS(LITERAL_BITS)) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_pos    (req_tdata),
      .in_fin    (req_tlast),
      .out_valid (d_valid),
      .out_ready (d_ready),
      .out_q     (d_q),
      .out_r     (d_r),
      .out_wep   (d_wep),
      .out_fin   (d_fin)
   );

   wahenc_encoder #(.LITERAL_BITS(LITERAL_BITS)) u_enc (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d_valid),
      .in_ready  (d_ready),
      .in_q      (d_q),
      .in_r      (d_r),
      .in_wep    (d_wep),
      .in_fin    (d_fin),
      .sink_free (sink_free),
      .bundle    (bundle)
   );

   wahenc_serializer u_ser (
      .clock     (clock),
      .reset     (reset),
      .bundle    (bundle),
      .free      (sink_free),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_word  (code_word),
      .out_last  (rsp_tlast),
      .out_total (total_bits)
   );

   assign rsp_tdata = {7'd0, total_bits, code_word};

   // Bundle only loads when the result register is free.
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      bundle.valid |-> sink_free)
      else $error("bundle loaded while result register busy");

   a_bundle_count: assert property (@(posedge clock) disable iff (reset)
      bundle.valid |-> (bundle.count != 3'd0 && bundle.count <= 3'd4))
      else $error("bundle word count out of range");

   a_total_final: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast ? (total_bits >= 33'(LITERAL_BITS)) : (total_bits == '0)))
      else $error("total_bits inconsistent with final_word");

   a_reset_idle: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

### tb/sv/wah_encode_sorted_positions_checker.sv
// Scoreboard for the WAH encoder: watches both stream channels, predicts the
// code words of each accepted position and compares them in order.
// Depends on wahenc_pkg for the code-word constants.
`timescale 1ns / 1ps

module wah_encode_sorted_positions_checker
   import wahenc_pkg::*;
#(
   parameter int LITERAL_BITS = 31
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] position
   input  logic        req_tlast,   // final_item
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [71:0] rsp_tdata,   // [31:0] code_word, [64:32] total_bits, [71:65] zero
   input  logic        rsp_tlast,   // final_word
   output int          mismatches,
   output int          words_due
);

   localparam logic [63:0] LBITS    = 64'(LITERAL_BITS);
   localparam logic [63:0] LIT_ONES = (64'd1 << LITERAL_BITS) - 64'd1;

   typedef struct packed {
      logic [CODE_W-1:0]  code_word;
      logic               final_word;
      logic [TOTAL_W-1:0] total_bits;
   } code_word_type;

   code_word_type     expected_words[$];

   logic [63:0]       bits_acc;
   logic [63:0]       word_last_pos;
   logic [CODE_W-1:0] pending_word;
   logic              pending_valid;
   logic              in_bitmap;

   task automatic emit_word(input logic [CODE_W-1:0] w, input logic fin,
                            input logic [TOTAL_W-1:0] bits);
      code_word_type e;
      e.code_word  = w;
      e.final_word = fin;
      e.total_bits = bits;
      expected_words.insert(expected_words.size(), e);
   endtask

   task automatic stage_word(input logic [CODE_W-1:0] w);
      if (pending_valid)
         emit_word(pending_word, 1'b0, '0);
      pending_word  = w;
      pending_valid = 1'b1;
   endtask

   task automatic finish_literal();
      if (bits_acc == LIT_ONES) begin
         if (pending_valid && (pending_word & W_ONEFILL) == W_ONEFILL &&
             pending_word != W_ONEFULL)
            pending_word = pending_word + 32'd1;
         else
            stage_word(W_ONEFILL | 32'd1);
      end else begin
         stage_word(bits_acc[31:0]);
      end
   endtask

   task automatic restart_bitmap();
      bits_acc      = '0;
      word_last_pos = LBITS - 64'd1;
      pending_word  = '0;
      pending_valid = 1'b0;
      in_bitmap     = 1'b0;
   endtask

   task automatic encode_position(input logic [31:0] pos, input logic fin);
      logic [63:0] p;
      logic [63:0] gap;
      logic [63:0] word_start;
      logic [63:0] bit_len;
      p = {32'd0, pos};
      if (!in_bitmap) begin
         gap           = p / LBITS;
         word_last_pos = (LBITS - 64'd1) + gap * LBITS;
         bits_acc      = '0;
         if (gap != 0)
            stage_word(W_FILL | (gap[31:0] & W_COUNTMASK));
         in_bitmap = 1'b1;
      end
      word_start = word_last_pos - (LBITS - 64'd1);
      if (p > word_last_pos) begin
         finish_literal();
         gap = (p - word_last_pos - 64'd1) / LBITS;
         if (gap != 0)
            stage_word(W_FILL | (gap[31:0] & W_COUNTMASK));
         word_last_pos = word_last_pos + (gap + 64'd1) * LBITS;
         bits_acc      = 64'd1 << ((word_last_pos - p) & 64'd63);
      end else if (p >= word_start) begin
         bits_acc = bits_acc | (64'd1 << ((word_last_pos - p) & 64'd63));
      end
      // positions below the word start are dropped
      if (fin) begin
         finish_literal();
         bit_len = word_last_pos + 64'd1;
         emit_word(pending_word, 1'b1, bit_len[TOTAL_W-1:0]);
         restart_bitmap();
      end
   endtask

   task automatic flag_mismatch(input string field, input logic [63:0] want,
                                input logic [63:0] got);
      mismatches++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
   endtask

   always @(posedge clock) begin
      code_word_type e;
      if (reset) begin
         restart_bitmap();
         expected_words.delete();
      end else begin
         // check output first so a same-edge input cannot mask a stray word
         if (rsp_tvalid && rsp_tready) begin
            if (expected_words.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected word, expected none, actual %h",
                        $time, rsp_tdata);
            end else begin
               e = expected_words.pop_front();
               if (rsp_tdata[31:0] !== e.code_word)
                  flag_mismatch("code_word", 64'(e.code_word), 64'(rsp_tdata[31:0]));
               if (rsp_tlast !== e.final_word)
                  flag_mismatch("final_word", 64'(e.final_word), 64'(rsp_tlast));
               if (rsp_tdata[64:32] !== e.total_bits)
                  flag_mismatch("total_bits", 64'(e.total_bits), 64'(rsp_tdata[64:32]));
               if (rsp_tdata[71:65] !== 7'd0)
                  flag_mismatch("padding", 64'd0, 64'(rsp_tdata[71:65]));
            end
         end
         if (req_tvalid && req_tready)
            encode_position(req_tdata, req_tlast);
      end
      words_due = expected_words.size();
   end

endmodule

### tb/sv/wah_encode_sorted_positions_core_test.sv
// Top of the WAH encoder testbench: drives mostly sorted position streams (with some
// out-of-order positions), random idling and one long output hold-off, and reports the verdict.
// Depends on the encoder core and wah_encode_sorted_positions_checker.
`timescale 1ns / 1ps

module wah_encode_sorted_positions_core_test;

   localparam int LITERAL_BITS  = 31;
   localparam int RANDOM_ITEMS  = 200;
   localparam int HOLD_CYCLES   = 300;
   localparam int DRAIN_CYCLES  = 12;
   localparam int CYCLE_LIMIT   = 400000;
   localparam logic [63:0] LBITS   = 64'(LITERAL_BITS);
   localparam logic [63:0] POS_MAX = 64'hFFFF_FFFF;

   typedef struct packed {
      logic [31:0] pos;
      logic        fin;
   } position_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic        rsp_tlast;
   int          mismatches;
   int          words_due;

   position_item_type positions[$];
   int                cycle_count = 0;
   int                rsp_seen = 0;

   always #10 clock = ~clock;

   wah_encode_sorted_positions_core #(
      .LITERAL_BITS(LITERAL_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   wah_encode_sorted_positions_checker #(
      .LITERAL_BITS(LITERAL_BITS)
   ) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .mismatches (mismatches),
      .words_due  (words_due)
   );

   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [63:0] clamp_pos(input logic [63:0] v);
      return (v > POS_MAX) ? POS_MAX : v;
   endfunction

   task automatic add_position(input logic [63:0] pos, input logic fin);
      position_item_type it;
      it.pos = pos[31:0];
      it.fin = fin;
      positions.insert(positions.size(), it);
   endtask

   task automatic add_random_bitmap(input bit dense);
      logic [63:0] cur;
      logic [63:0] aligned;
      int          words;
      int          n;
      int          r;
      case ($urandom_range(0, 9))
         6, 7:    cur = 64'($urandom);
         8:       cur = 64'hFFFF_FF00 + 64'($urandom_range(0, 255));
         9:       cur = POS_MAX - 64'($urandom_range(0, 5000));
         default: cur = 64'($urandom_range(0, 300));
      endcase
      if (dense) begin
         // whole words of set bits: one-fills and their extension
         words   = $urandom_range(1, 3);
         aligned = (cur / LBITS) * LBITS;
         if (aligned + LBITS * 64'(words) - 64'd1 > POS_MAX)
            aligned = aligned - LBITS * 64'(words);
         for (int j = 0; j < LITERAL_BITS * words; j++)
            add_position(aligned + 64'(j), 1'b0);
         cur = aligned + LBITS * 64'(words) - 64'd1;
      end
      n = $urandom_range(1, 10);
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 19);
         if (r >= 18 && cur >= 64'd100) begin
            add_position(cur - 64'($urandom_range(1, 100)), i == n - 1);
         end else begin
            if (r inside {[4:9]})
               cur = cur + 64'($urandom_range(1, 6));
            else if (r inside {[10:13]})
               cur = cur + 64'($urandom_range(20, 70));
            else if (r inside {14, 15})
               cur = cur + 64'($urandom_range(100, 5000));
            else if (r == 16)
               cur = cur + 64'($urandom_range(0, 1 << 24));
            else if (r == 17)
               cur = cur + 64'($urandom);
            cur = clamp_pos(cur);
            add_position(cur, i == n - 1);
         end
      end
   endtask

   task automatic build_stimulus();
      int target;
      // single-bit bitmaps at the word edges and the top of the range
      add_position(64'd0, 1'b1);
      add_position(64'd30, 1'b1);
      add_position(64'd31, 1'b1);
      add_position(POS_MAX, 1'b1);
      // duplicate, next word, gap fill, dropped position
      add_position(64'd5, 1'b0);
      add_position(64'd5, 1'b0);
      add_position(64'd12, 1'b0);
      add_position(64'd40, 1'b0);
      add_position(64'd200, 1'b0);
      add_position(64'd100, 1'b0);
      add_position(64'd201, 1'b0);
      add_position(64'd230, 1'b1);
      // final flag on a dropped position
      add_position(64'd1000, 1'b0);
      add_position(64'd900, 1'b1);
      // leading zero fill, large gaps, drop, end of range
      add_position(64'd62, 1'b0);
      add_position(64'd63, 1'b0);
      add_position(64'd2000000, 1'b0);
      add_position(64'hAAAA_AAAA, 1'b0);
      add_position(64'h5555_5555, 1'b0);
      add_position(64'hFFFF_FFF0, 1'b0);
      add_position(POS_MAX, 1'b1);
      target = positions.size() + RANDOM_ITEMS;
      add_random_bitmap(1'b1);
      while (positions.size() < target)
         add_random_bitmap($urandom_range(0, 5) == 0);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // output side: random stalls, plus one long hold-off to back up the block
   initial begin
      int  stall;
      int  burst;
      bit  held_off;
      held_off = 1'b0;
      repeat (6) @(posedge clock);
      forever begin
         if (!held_off && rsp_seen >= 24) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            held_off = 1'b1;
         end
         stall = idle_length();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         burst = $urandom_range(1, 40);
         repeat (burst) begin
            @(posedge clock);
            if (rsp_tvalid && rsp_tready)
               rsp_seen++;
         end
      end
   end

   initial begin
      int                gap;
      position_item_type it;
      build_stimulus();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      while (positions.size() > 0) begin
         it  = positions.pop_front();
         gap = idle_length();
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= it.pos;
         req_tlast  <= it.fin;
         do
            @(posedge clock);
         while (!req_tready);
      end
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (words_due != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
